>>> hdl/gmcs_pkg.sv
// Shared types and constants for the greedy minimum-completion scheduler.
// Depends on nothing; imported by the scheduler top module.
package gmcs_pkg;

    // Machine count and derived widths
    localparam int NUM_MACHINES = 8;
    localparam int MI_W         = (NUM_MACHINES > 1) ? $clog2(NUM_MACHINES) : 1;
    localparam int CNT_W        = $clog2(NUM_MACHINES + 1);

    // Field widths
    localparam int SPEED_W  = 8;
    localparam int LEN_W    = 16;
    localparam int LOAD_W   = 32;
    localparam int PROD_W   = SPEED_W + LEN_W;
    localparam int SUM_W    = LOAD_W + 1;
    localparam int IDX_W    = 3;
    localparam int ENTRY_W  = SPEED_W + LOAD_W;

    // Opcodes
    localparam logic OP_SET_SPEED = 1'b0;
    localparam logic OP_ASSIGN    = 1'b1;

    // Speed factor of a machine that was never written
    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(1);

    typedef struct packed {
        logic               opcode;
        logic [IDX_W-1:0]   machine_index;
        logic [SPEED_W-1:0] speed_value;
        logic [LEN_W-1:0]   job_length;
    } gmcs_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]  chosen_machine;
        logic [LOAD_W-1:0] finish_time;
        logic              saturated;
    } gmcs_out_t;

    // One machine's stored entry
    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [LOAD_W-1:0]  load;
    } gmcs_entry_t;

endpackage

>>> hdl/gmcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module gmcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write, and register the read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/greedy_min_completion_scheduler.sv
// Set-speed beat: taken with no result. Assign beat: the result is built by one RAM read per
// machine in turn, one product-and-sum stage, one compare, then the write-back that loads the
// result register. The next beat is taken after that write-back; a full result register holds
// the write-back and the input. A new beat is taken while a result waits.
// Reset (aresetn, synchronous, active low) clears control and the per-machine valid bits.
module greedy_min_completion_scheduler
    import gmcs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  gmcs_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output gmcs_out_t m_data
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    localparam logic [MI_W-1:0] LAST_IDX = MI_W'(NUM_MACHINES - 1);

    state_t             state_reg, state_next;
    logic [NUM_MACHINES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    // Read stage
    logic               rd_pend_reg, rd_pend_next;
    logic [MI_W-1:0]    rd_idx_reg, rd_idx_next;
    logic               rd_vld_reg, rd_vld_next;
    // Sum stage
    logic               sum_vld_reg, sum_vld_next;
    logic [MI_W-1:0]    sum_idx_reg, sum_idx_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SPEED_W-1:0] sum_speed_reg, sum_speed_next;
    // Best so far
    logic [MI_W-1:0]    best_idx_reg, best_idx_next;
    logic [SUM_W-1:0]   best_sum_reg, best_sum_next;
    logic [SPEED_W-1:0] best_speed_reg, best_speed_next;
    // Output register
    logic               m_valid_reg, m_valid_next;
    gmcs_out_t          m_data_reg, m_data_next;

    // RAM ports
    logic               ram_we;
    logic [MI_W-1:0]    ram_waddr;
    gmcs_entry_t        ram_wdata;
    logic [MI_W-1:0]    ram_raddr;
    gmcs_entry_t        ram_rdata;
    logic               rd_en;

    logic               s_fire;
    logic               out_free;
    logic               set_ok;
    gmcs_entry_t        rd_entry;
    logic [PROD_W-1:0]  prod;
    logic               sat;
    logic [LOAD_W-1:0]  new_load;

    gmcs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_MACHINES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign set_ok   = (int'(s_data.machine_index) < NUM_MACHINES);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Substitute the reset value for entries never written
    always_comb begin
        if (rd_vld_reg) begin
            rd_entry = ram_rdata;
        end else begin
            rd_entry.speed = SPEED_RESET;
            rd_entry.load  = '0;
        end
    end

    assign prod     = PROD_W'(rd_entry.speed) * PROD_W'(len_reg);
    assign sat      = best_sum_reg[LOAD_W];
    assign new_load = sat ? '1 : best_sum_reg[LOAD_W-1:0];

    // Read address: first entry at accept, then walk the counter
    always_comb begin
        rd_en     = 1'b0;
        ram_raddr = '0;
        if (state_reg == ST_IDLE) begin
            rd_en = s_fire && (s_data.opcode == OP_ASSIGN);
        end else if (state_reg == ST_SCAN) begin
            rd_en     = (rd_cnt_reg < CNT_W'(NUM_MACHINES));
            ram_raddr = rd_cnt_reg[MI_W-1:0];
        end
    end

    // Write port: set-speed at accept, or write-back of the chosen machine
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = best_idx_reg;
        ram_wdata.speed = best_speed_reg;
        ram_wdata.load  = new_load;
        if (state_reg == ST_IDLE) begin
            ram_we          = s_fire && (s_data.opcode == OP_SET_SPEED) && set_ok;
            ram_waddr       = MI_W'(s_data.machine_index);
            ram_wdata.speed = s_data.speed_value;
            ram_wdata.load  = '0;
        end else if (state_reg == ST_WRITE) begin
            ram_we = out_free;
        end
    end

    // Next-state logic
    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        rd_cnt_next     = rd_cnt_reg;
        len_next        = len_reg;
        rd_pend_next    = rd_en;
        rd_idx_next     = ram_raddr;
        rd_vld_next     = valid_reg[ram_raddr];
        sum_vld_next    = rd_pend_reg;
        sum_idx_next    = rd_idx_reg;
        sum_next        = SUM_W'(rd_entry.load) + SUM_W'(prod);
        sum_speed_next  = rd_entry.speed;
        best_idx_next   = best_idx_reg;
        best_sum_next   = best_sum_reg;
        best_speed_next = best_speed_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        // Mark written entries
        if (ram_we) begin
            valid_next[ram_waddr] = 1'b1;
        end

        // Keep the smallest sum, lowest index on ties
        if (sum_vld_reg && (sum_idx_reg == '0 || sum_reg < best_sum_reg)) begin
            best_idx_next   = sum_idx_reg;
            best_sum_next   = sum_reg;
            best_speed_next = sum_speed_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.opcode == OP_ASSIGN) begin
                    len_next    = s_data.job_length;
                    rd_cnt_next = CNT_W'(1);
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (sum_vld_reg && sum_idx_reg == LAST_IDX) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // Hold until the output register is free
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.chosen_machine  = IDX_W'(best_idx_reg);
                    m_data_next.finish_time     = new_load;
                    m_data_next.saturated       = sat;
                    rd_cnt_next                 = '0;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            rd_cnt_reg  <= '0;
            rd_pend_reg <= 1'b0;
            sum_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            rd_cnt_reg  <= rd_cnt_next;
            rd_pend_reg <= rd_pend_next;
            sum_vld_reg <= sum_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        len_reg        <= len_next;
        rd_idx_reg     <= rd_idx_next;
        rd_vld_reg     <= rd_vld_next;
        sum_idx_reg    <= sum_idx_next;
        sum_reg        <= sum_next;
        sum_speed_reg  <= sum_speed_next;
        best_idx_reg   <= best_idx_next;
        best_sum_reg   <= best_sum_next;
        best_speed_reg <= best_speed_next;
        m_data_reg     <= m_data_next;
    end

    // No scan work in flight while a new beat can be taken
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!rd_pend_reg && !sum_vld_reg))
        else $error("scan pipeline busy while accepting");

    // Walk counter never runs past the last machine
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_cnt_reg <= CNT_W'(NUM_MACHINES))
        else $error("read counter out of range");

    // A clamped result reports the maximum finish time
    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.saturated) |-> (m_data_reg.finish_time == '1))
        else $error("saturated result without maximum finish time");

    // Write-back always produces a result beat
    a_wb_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("write-back without result");

endmodule
